// ----- design/iirdf2_pkg.sv -----
package iirdf2_pkg;

   // Default filter order of the delay line
   localparam int ORDER_DEFAULT = 2;

   // Field and datapath widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int W_W      = 24;
   localparam int FRAC_W   = 14;
   localparam int PROD_W   = COEF_W + W_W - FRAC_W;
   localparam int ACC_W    = 30;
   localparam int TAP_W    = 2;
   localparam int ORD_W    = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   localparam logic [CSR_IDX_W-1:0] REG_ORDER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B1    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B2    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2    = 3'd5;

   // Register reset values
   localparam logic [ORD_W-1:0]         ORDER_RESET = 2'd2;
   localparam logic signed [COEF_W-1:0] B0_RESET    = 18'sd16384;

   // Most taps per side that have coefficients
   localparam int MAX_TAPS = 2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FB,
      ST_FB_DRAIN,
      ST_WSAT,
      ST_FF,
      ST_FF_DRAIN,
      ST_YSAT
   } state_type;

   // Controls for the shared multiply-accumulate unit
   typedef struct packed {
      logic issue;
      logic sub;
      logic acc_load;
   } mac_ctl_type;

   // Sequencer to datapath controls
   typedef struct packed {
      mac_ctl_type            mac;
      logic                   fwd;
      logic [TAP_W-1:0]       tap;
      logic                   load_x;
      logic                   w_latch;
      logic                   y_latch;
   } seq_ctl_type;

endpackage

// ----- design/iir_direct_form2_filter.sv -----
// Channel   | Direction | Beat contents
// req_      | in        | req_sample_in
// rsp_      | out       | rsp_sample_out, rsp_clipped
// csr_      | in        | csr_index, csr_data (write only)
//
// A sample takes n feedback and n+1 feedforward products, n being the order
// in use (1 or 2), on the single multiply-accumulate unit, which takes one
// product per cycle, with one pipeline drain after each side.
// Synchronous reset clears the delay line, the sequencer and the output
// valid flag, and sets the order and coefficient registers to their defaults.
// While an earlier result is held by rsp_stall, a new one waits in the last step.
module iir_direct_form2_filter #(
   parameter int ORDER = iirdf2_pkg::ORDER_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [iirdf2_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                    rsp_clipped,
   input  logic                                    csr_write,
   input  logic [iirdf2_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [iirdf2_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int NTAPS = (ORDER < iirdf2_pkg::MAX_TAPS) ? ORDER : iirdf2_pkg::MAX_TAPS;
   localparam int W_W   = iirdf2_pkg::W_W;
   localparam int ACC_W = iirdf2_pkg::ACC_W;
   localparam int SW    = iirdf2_pkg::SAMPLE_W;

   logic [iirdf2_pkg::ORD_W-1:0]            order_ff;
   logic signed [iirdf2_pkg::COEF_W-1:0]    b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [W_W-1:0]                   delay_ff [ORDER];
   logic signed [W_W-1:0]                   w_ff;
   logic                                    hit_ff;
   logic                                    rsp_valid_ff;
   logic signed [SW-1:0]                    rsp_sample_ff;
   logic                                    rsp_clipped_ff;

   logic [iirdf2_pkg::ORD_W-1:0]            n_taps;
   logic                                    out_free;
   iirdf2_pkg::seq_ctl_type                 ctl;
   logic signed [iirdf2_pkg::COEF_W-1:0]    coef_sel;
   logic signed [W_W-1:0]                   data_sel;
   logic signed [W_W-1:0]                   delay_sel;
   logic [iirdf2_pkg::TAP_W-1:0]            delay_idx;
   logic signed [ACC_W-1:0]                 load_value;
   logic signed [ACC_W-1:0]                 acc;
   logic                                    w_ovf;
   logic signed [W_W-1:0]                   w_sat;
   logic                                    y_ovf;
   logic signed [SW-1:0]                    y_sat;

   // Effective order: zero acts as one, capped at the taps that exist
   always_comb begin
      if (order_ff == '0) begin
         n_taps = 2'd1;
      end else if (order_ff > iirdf2_pkg::ORD_W'(NTAPS)) begin
         n_taps = iirdf2_pkg::ORD_W'(NTAPS);
      end else begin
         n_taps = order_ff;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= iirdf2_pkg::ORDER_RESET;
         b0_ff    <= iirdf2_pkg::B0_RESET;
         b1_ff    <= '0;
         b2_ff    <= '0;
         a1_ff    <= '0;
         a2_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            iirdf2_pkg::REG_ORDER: order_ff <= csr_data[iirdf2_pkg::ORD_W-1:0];
            iirdf2_pkg::REG_B0:    b0_ff    <= $signed(csr_data);
            iirdf2_pkg::REG_B1:    b1_ff    <= $signed(csr_data);
            iirdf2_pkg::REG_B2:    b2_ff    <= $signed(csr_data);
            iirdf2_pkg::REG_A1:    a1_ff    <= $signed(csr_data);
            iirdf2_pkg::REG_A2:    a2_ff    <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   iirdf2_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .n_taps    (n_taps),
      .req_stall (req_stall),
      .ctl       (ctl)
   );

   // Operand selection: feedback tap k uses d[k], feedforward tap k uses d[k-1]
   assign delay_idx = ctl.fwd ? (ctl.tap - 2'd1) : ctl.tap;

   always_comb begin
      delay_sel = '0;
      for (int k = 0; k < ORDER; k++) begin
         if (delay_idx == iirdf2_pkg::TAP_W'(k)) begin
            delay_sel = delay_ff[k];
         end
      end
   end

   always_comb begin
      if (ctl.fwd) begin
         case (ctl.tap)
            2'd0:    coef_sel = b0_ff;
            2'd1:    coef_sel = b1_ff;
            default: coef_sel = b2_ff;
         endcase
         data_sel = (ctl.tap == '0) ? w_ff : delay_sel;
      end else begin
         coef_sel = (ctl.tap == '0) ? a1_ff : a2_ff;
         data_sel = delay_sel;
      end
   end

   assign load_value = ctl.load_x ? ACC_W'(req_sample_in) : '0;

   iirdf2_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl.mac),
      .coef       (coef_sel),
      .data       (data_sel),
      .load_value (load_value),
      .acc        (acc)
   );

   // Saturation of w to 24 bits and y to 16 bits
   assign w_ovf = (acc[ACC_W-1:W_W-1] != '0) && (acc[ACC_W-1:W_W-1] != '1);
   assign w_sat = w_ovf ? (acc[ACC_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}})
                        : acc[W_W-1:0];
   assign y_ovf = (acc[ACC_W-1:SW-1] != '0) && (acc[ACC_W-1:SW-1] != '1);
   assign y_sat = y_ovf ? (acc[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                        : acc[SW-1:0];

   // Latched w and its clip flag
   always_ff @(posedge clock) begin
      if (ctl.w_latch) begin
         w_ff   <= w_sat;
         hit_ff <= w_ovf;
      end
   end

   // Delay line shifts in w once the output is formed
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER; k++) begin
            delay_ff[k] <= '0;
         end
      end else if (ctl.y_latch) begin
         delay_ff[0] <= w_ff;
         for (int k = 1; k < ORDER; k++) begin
            delay_ff[k] <= delay_ff[k-1];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.y_latch) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.y_latch) begin
         rsp_sample_ff  <= y_sat;
         rsp_clipped_ff <= hit_ff | y_ovf;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

// ----- design/iirdf2_mac.sv -----
module iirdf2_mac (
   input  logic                                       clock,
   input  logic                                       reset,
   input  iirdf2_pkg::mac_ctl_type                    ctl,
   input  logic signed [iirdf2_pkg::COEF_W-1:0]       coef,
   input  logic signed [iirdf2_pkg::W_W-1:0]          data,
   input  logic signed [iirdf2_pkg::ACC_W-1:0]        load_value,
   output logic signed [iirdf2_pkg::ACC_W-1:0]        acc
);

   localparam int FULL_W = iirdf2_pkg::COEF_W + iirdf2_pkg::W_W;

   logic signed [FULL_W-1:0]              prod_full;
   logic signed [iirdf2_pkg::PROD_W-1:0]  prod_ff;
   logic                                  pend_ff;
   logic                                  pend_sub_ff;
   logic signed [iirdf2_pkg::ACC_W-1:0]   acc_ff;
   logic signed [iirdf2_pkg::ACC_W-1:0]   prod_ext;

   // Full product; dropping the low fraction bits of a signed value floors it
   assign prod_full = coef * data;
   assign prod_ext  = iirdf2_pkg::ACC_W'(prod_ff);

   // Product register
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         prod_ff <= prod_full[FULL_W-1:iirdf2_pkg::FRAC_W];
      end
   end

   // Pending-product flags, set in the cycle after the issue
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         pend_sub_ff <= 1'b0;
      end else begin
         pend_ff     <= ctl.issue;
         pend_sub_ff <= ctl.sub;
      end
   end

   // Accumulator
   always_ff @(posedge clock) begin
      if (ctl.acc_load) begin
         acc_ff <= load_value;
      end else if (pend_ff) begin
         if (pend_sub_ff) begin
            acc_ff <= acc_ff - prod_ext;
         end else begin
            acc_ff <= acc_ff + prod_ext;
         end
      end
   end

   assign acc = acc_ff;

endmodule

// ----- design/iirdf2_seq.sv -----
module iirdf2_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 out_free,
   input  logic [iirdf2_pkg::ORD_W-1:0]         n_taps,
   output logic                                 req_stall,
   output iirdf2_pkg::seq_ctl_type              ctl
);

   iirdf2_pkg::state_type            state_ff, state_in;
   logic [iirdf2_pkg::TAP_W-1:0]     tap_ff, tap_in;
   logic [iirdf2_pkg::TAP_W-1:0]     last_fb;

   assign last_fb = iirdf2_pkg::TAP_W'(n_taps - 2'd1);

   // State and tap counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iirdf2_pkg::ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   // Next state and controls
   always_comb begin
      state_in         = state_ff;
      tap_in           = tap_ff;
      req_stall        = 1'b1;
      ctl              = '0;
      ctl.tap          = tap_ff;
      case (state_ff)
         iirdf2_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.mac.acc_load = 1'b1;
               ctl.load_x       = 1'b1;
               tap_in           = '0;
               state_in         = iirdf2_pkg::ST_FB;
            end
         end
         // feedback taps: acc -= a_i * d[i-1]
         iirdf2_pkg::ST_FB: begin
            ctl.mac.issue = 1'b1;
            ctl.mac.sub   = 1'b1;
            if (tap_ff == last_fb) begin
               tap_in   = '0;
               state_in = iirdf2_pkg::ST_FB_DRAIN;
            end else begin
               tap_in = tap_ff + 2'd1;
            end
         end
         iirdf2_pkg::ST_FB_DRAIN: begin
            state_in = iirdf2_pkg::ST_WSAT;
         end
         // w is final: latch it and clear the accumulator
         iirdf2_pkg::ST_WSAT: begin
            ctl.w_latch      = 1'b1;
            ctl.mac.acc_load = 1'b1;
            tap_in           = '0;
            state_in         = iirdf2_pkg::ST_FF;
         end
         // feedforward: b0 * w, then b_i * d[i-1]
         iirdf2_pkg::ST_FF: begin
            ctl.mac.issue = 1'b1;
            ctl.fwd       = 1'b1;
            if (tap_ff == iirdf2_pkg::TAP_W'(n_taps)) begin
               tap_in   = '0;
               state_in = iirdf2_pkg::ST_FF_DRAIN;
            end else begin
               tap_in = tap_ff + 2'd1;
            end
         end
         iirdf2_pkg::ST_FF_DRAIN: begin
            state_in = iirdf2_pkg::ST_YSAT;
         end
         // hand the result over once the output register is free
         iirdf2_pkg::ST_YSAT: begin
            if (out_free) begin
               ctl.y_latch = 1'b1;
               state_in    = iirdf2_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iirdf2_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- dv/tb_iir_direct_form2_filter.sv -----
module tb_iir_direct_form2_filter;

   localparam int ORDER            = iirdf2_pkg::ORDER_DEFAULT;
   localparam int SETTLE_CYCLES    = 24;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RAND_PHASES      = 12;
   localparam int PHASE_ITEMS      = 115;
   localparam int MAX_REPORTS      = 40;

   localparam int SAMPLE_W   = iirdf2_pkg::SAMPLE_W;
   localparam int COEF_W     = iirdf2_pkg::COEF_W;
   localparam int W_W        = iirdf2_pkg::W_W;
   localparam int FRAC_W     = iirdf2_pkg::FRAC_W;
   localparam int ORD_W      = iirdf2_pkg::ORD_W;
   localparam int MAX_TAPS   = iirdf2_pkg::MAX_TAPS;
   localparam int CSR_IDX_W  = iirdf2_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = iirdf2_pkg::CSR_DATA_W;

   // Register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   // Coefficient selection styles for the random settings
   localparam int COEF_ANY     = 0;
   localparam int COEF_STABLE  = 1;
   localparam int COEF_EXTREME = 2;

   localparam longint W_HI = (longint'(1) << (W_W - 1)) - 1;
   localparam longint W_LO = -(longint'(1) << (W_W - 1));
   localparam longint Y_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint Y_LO = -(longint'(1) << (SAMPLE_W - 1));

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } filtered_beat_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_clipped;
   logic                       csr_write      = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index      = '0;
   logic [CSR_DATA_W-1:0]      csr_data       = '0;

   // Filter state and settings as the block should hold them
   logic [ORD_W-1:0]           order_cfg = iirdf2_pkg::ORDER_RESET;
   logic signed [COEF_W-1:0]   ff_coef [3];
   logic signed [COEF_W-1:0]   fb_coef [2];
   logic signed [W_W-1:0]      delay_w [ORDER];

   logic signed [SAMPLE_W-1:0] sample_queue [$];
   filtered_beat_type          filter_due [$];

   logic quiet_phase = 1'b0;
   logic req_fired   = 1'b0;
   int   req_gap     = 0;
   int   stall_left  = 0;
   int   idle_cycles = 0;
   int   mismatch_count  = 0;
   int   samples_sent    = 0;
   int   results_checked = 0;
   int   clipped_seen    = 0;
   int   settings_used   = 0;

   iir_direct_form2_filter #(.ORDER(ORDER)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // Mostly short gaps, now and then a long one; none in quiet phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet_phase)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return SAMPLE_W'($urandom);
      if (r < 85)
         return SAMPLE_W'(int'($urandom_range(512)) - 256);
      return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_coef(input int style, input int span);
      int r;
      r = $urandom_range(4);
      case (style)
         COEF_STABLE: return CSR_DATA_W'(int'($urandom_range(2 * span)) - span);
         COEF_EXTREME: begin
            case (r)
               0:       return 18'h1FFFF;
               1:       return 18'h20000;
               2:       return 18'h00000;
               3:       return 18'h04000;
               default: return 18'h3C000;
            endcase
         end
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // One output beat from one input sample; advances the delay line
   function automatic void compute_filtered(input logic signed [SAMPLE_W-1:0] x,
                                            output filtered_beat_type beat);
      int     taps;
      int     i;
      longint w_acc;
      longint y_acc;
      taps = int'(order_cfg);
      if (taps < 1)
         taps = 1;
      if (taps > ORDER)
         taps = ORDER;
      if (taps > MAX_TAPS)
         taps = MAX_TAPS;
      beat.clipped = 1'b0;

      // feedback side, each product floored
      w_acc = longint'(x);
      for (i = 0; i < taps; i++)
         w_acc -= (longint'(fb_coef[i]) * longint'(delay_w[i])) >>> FRAC_W;
      if (w_acc > W_HI) begin
         w_acc = W_HI;
         beat.clipped = 1'b1;
      end else if (w_acc < W_LO) begin
         w_acc = W_LO;
         beat.clipped = 1'b1;
      end

      // feedforward side
      y_acc = (longint'(ff_coef[0]) * w_acc) >>> FRAC_W;
      for (i = 0; i < taps; i++)
         y_acc += (longint'(ff_coef[i + 1]) * longint'(delay_w[i])) >>> FRAC_W;
      if (y_acc > Y_HI) begin
         y_acc = Y_HI;
         beat.clipped = 1'b1;
      end else if (y_acc < Y_LO) begin
         y_acc = Y_LO;
         beat.clipped = 1'b1;
      end
      beat.sample = y_acc[SAMPLE_W-1:0];

      // whole line shifts, whatever the order in use
      for (i = ORDER - 1; i > 0; i--)
         delay_w[i] = delay_w[i - 1];
      delay_w[0] = w_acc[W_W-1:0];
   endfunction

   // Register write; the block is idle, so the local copy follows at once
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         iirdf2_pkg::REG_ORDER: order_cfg  = val[ORD_W-1:0];
         iirdf2_pkg::REG_B0:    ff_coef[0] = val;
         iirdf2_pkg::REG_B1:    ff_coef[1] = val;
         iirdf2_pkg::REG_B2:    ff_coef[2] = val;
         iirdf2_pkg::REG_A1:    fb_coef[0] = val;
         iirdf2_pkg::REG_A2:    fb_coef[1] = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_order(input int ord);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      word[ORD_W-1:0] = ORD_W'(ord);
      write_reg(iirdf2_pkg::REG_ORDER, word);
   endtask

   // Wait for every queued sample to go in and every beat to come back
   task automatic settle();
      while (sample_queue.size() != 0 || filter_due.size() != 0 || req_valid ||
             samples_sent != results_checked)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      settings_used++;
   endtask

   // Input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            req_valid     <= 1'b1;
            req_sample_in <= sample_queue.pop_front();
            samples_sent++;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(3) == 0)
            stall_left = pick_gap();
      end
   end

   // Monitor: predict on accepted samples, check accepted beats
   always @(posedge clock) begin
      filtered_beat_type due;
      filtered_beat_type fresh;
      logic              rsp_fired;
      if (reset) begin
         req_fired   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired = req_valid && !req_stall;
         rsp_fired = rsp_valid && !rsp_stall;
         if (req_fired) begin
            compute_filtered(req_sample_in, fresh);
            filter_due.push_back(fresh);
         end
         if (rsp_fired) begin
            results_checked++;
            if (rsp_clipped === 1'b1)
               clipped_seen++;
            if (filter_due.size() == 0) begin
               report_mismatch($sformatf("beat %0d with nothing pending", rsp_sample_out));
            end else begin
               due = filter_due.pop_front();
               if (rsp_sample_out !== due.sample)
                  report_mismatch($sformatf("sample_out %0d, wanted %0d",
                                            rsp_sample_out, due.sample));
               if (rsp_clipped !== due.clipped)
                  report_mismatch($sformatf("clipped %b, wanted %b",
                                            rsp_clipped, due.clipped));
            end
         end
         if (req_fired || rsp_fired || csr_write)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats still due",
                     idle_cycles, filter_due.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Stimulus sequence
   initial begin
      int phase;
      int style;
      ff_coef[0] = iirdf2_pkg::B0_RESET;
      ff_coef[1] = '0;
      ff_coef[2] = '0;
      fb_coef[0] = '0;
      fb_coef[1] = '0;
      for (int k = 0; k < ORDER; k++)
         delay_w[k] = '0;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset settings: plain pass-through, field extremes
      sample_queue = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sd12345};
      settle();

      // order zero behaves as one; tiny negative gain shows floor rounding;
      // writes to undecoded indexes must leave everything alone
      write_order(0);
      write_reg(iirdf2_pkg::REG_B0, 18'h3FFFF);
      write_reg(iirdf2_pkg::REG_B1, 18'h00001);
      write_reg(REG_SPARE_LO, CSR_DATA_W'($urandom));
      write_reg(REG_SPARE_HI, CSR_DATA_W'($urandom));
      sample_queue = '{16'sd1, -16'sd1, 16'sd3, 16'sh8000};
      settle();

      // order above the limit, extreme coefficients: w and output saturate
      write_order(3);
      write_reg(iirdf2_pkg::REG_B0, 18'h1FFFF);
      write_reg(iirdf2_pkg::REG_B1, 18'h20000);
      write_reg(iirdf2_pkg::REG_B2, 18'h1FFFF);
      write_reg(iirdf2_pkg::REG_A1, 18'h20000);
      write_reg(iirdf2_pkg::REG_A2, 18'h1FFFF);
      sample_queue = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                       16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      settle();

      // order one: second taps must not contribute
      write_order(1);
      write_reg(iirdf2_pkg::REG_B0, 18'h04000);
      write_reg(iirdf2_pkg::REG_A1, 18'h04000);
      write_reg(iirdf2_pkg::REG_B2, 18'h20000);
      sample_queue = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5};
      settle();

      // random settings, each followed by a block of random samples
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         quiet_phase = (phase % 4 == 3);
         style = (phase == 0) ? COEF_EXTREME : phase % 3;
         write_order(phase % 4);
         write_reg(iirdf2_pkg::REG_B0, pick_coef(style, 16384));
         write_reg(iirdf2_pkg::REG_B1, pick_coef(style, 16384));
         write_reg(iirdf2_pkg::REG_B2, pick_coef(style, 16384));
         write_reg(iirdf2_pkg::REG_A1, pick_coef(style, 16000));
         write_reg(iirdf2_pkg::REG_A2, pick_coef(style, 8000));
         if ($urandom_range(1))
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CSR_DATA_W'($urandom));
         repeat (PHASE_ITEMS) sample_queue.push_back(pick_sample());
         settle();
      end

      $display("%0d samples sent over %0d coefficient settings (orders 0 to 3 written)",
               samples_sent, settings_used);
      $display("%0d output beats checked, %0d of them saturated", results_checked,
               clipped_seen);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- iir_direct_form2_filter.f -----
design/iirdf2_pkg.sv
design/iirdf2_mac.sv
design/iirdf2_seq.sv
design/iir_direct_form2_filter.sv
dv/tb_iir_direct_form2_filter.sv
